// ----- rtl/drum_step_sequencer_top_macros.svh -----
// ----------------------------------------------------------------------------
// drum step sequencer assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef DRUM_STEP_SEQUENCER_TOP_MACROS_SVH
`define DRUM_STEP_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define DSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// types and constants shared by the drum step sequencer modules
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned DEN_W      = 25;
  localparam int unsigned STEP_W     = 9;
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned CFG_W      = 10;
  localparam int unsigned FRAMES_BPM = 15360;

  localparam logic [12:0] CHUNK_LIMIT  = 13'd4096;
  localparam logic [6:0]  VEL_MAX      = 7'd127;
  localparam logic [4:0]  BPB_DEFAULT  = 5'd4;
  localparam logic [9:0]  VOLUME_RESET = 10'd256;
  localparam logic [6:0]  SPB_RESET    = 7'd16;
  localparam logic [4:0]  BPB_RESET    = 5'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CLIP  = 2'd1,
    OP_HIT   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_VOLUME = 2'd0,
    REG_MUTE   = 2'd1,
    REG_SPB    = 2'd2,
    REG_BPB    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_TPF = 2'd0,
    SEL_CUR = 2'd1,
    SEL_SF  = 2'd2
  } arith_sel_e;

  typedef struct packed {
    logic       mul_go;
    logic       div_go;
    arith_sel_e sel;
    logic       save_tpf;
    logic       save_cur;
    logic       save_off;
    logic       step_init;
    logic       step_inc;
    logic       upd_last;
    logic       hit_rd;
    logic       hit_ev;
    logic       emit_final;
  } dss_cmd_t;

  typedef struct packed {
    logic silent;
    logic arith_done;
    logic clip_live;
    logic pos_ok;
    logic cur_new;
    logic step_last;
    logic ev_wait;
    logic out_free;
  } dss_sts_t;

endpackage

// ----- rtl/dss_arith.sv -----
// ----------------------------------------------------------------------------
// dss_arith
// bit-serial multiplier and restoring divider sharing one accumulator
// ----------------------------------------------------------------------------
module dss_arith #(
  parameter int unsigned DivW = 45,
  parameter int unsigned NumW = 35,
  localparam int unsigned CntW = $clog2(DivW + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      mul_go_i,
  input  logic                      div_go_i,
  input  logic [DivW-1:0]           a_i,
  input  logic [dss_pkg::DEN_W-1:0] b_i,
  input  logic [NumW-1:0]           d_i,
  output logic                      done_o,
  output logic [DivW-1:0]           p_o
);
  import dss_pkg::*;

  logic            busy_q, is_div_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] acc_q, a_q;
  logic [DEN_W-1:0] b_q;
  logic [NumW-1:0] d_q, rem_q;
  logic [NumW:0]   r2;
  logic            q_bit;

  assign r2    = {rem_q, acc_q[DivW-1]};
  assign q_bit = r2 >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (mul_go_i) begin
        busy_q   <= 1'b1;
        is_div_q <= 1'b0;
        cnt_q    <= CntW'(DEN_W);
      end else if (div_go_i) begin
        busy_q   <= 1'b1;
        is_div_q <= 1'b1;
        cnt_q    <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_go_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (div_go_i) begin
      rem_q <= '0;
      d_q   <= d_i;
    end else if (busy_q) begin
      if (is_div_q) begin
        rem_q <= q_bit ? NumW'(r2 - {1'b0, d_q}) : r2[NumW-1:0];
        acc_q <= {acc_q[DivW-2:0], q_bit};
      end else begin
        acc_q <= {acc_q[DivW-2:0], 1'b0} + (b_q[DEN_W-1] ? a_q : '0);
        b_q   <= {b_q[DEN_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- rtl/dss_datapath.sv -----
// ----------------------------------------------------------------------------
// dss_datapath
// registers, clip and hit storage, step arithmetic and the result register
// ----------------------------------------------------------------------------
module dss_datapath #(
  parameter int unsigned MAX_CLIPS     = 4,
  parameter int unsigned HITS_PER_CLIP = 32,
  parameter int unsigned SAMPLE_RATE   = 48000,
  parameter int unsigned MAX_EVENTS    = 64,
  localparam int unsigned ClipW = MAX_CLIPS > 1 ? $clog2(MAX_CLIPS) : 1,
  localparam int unsigned HitW  = HITS_PER_CLIP > 1 ? $clog2(HITS_PER_CLIP) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  dss_pkg::opcode_e       opcode_i,
  input  logic [47:0]            render_pos_i,
  input  logic [12:0]            chunk_frames_i,
  input  logic [17:0]            bpm_x256_i,
  input  logic [1:0]             clip_index_i,
  input  logic [4:0]             hit_index_i,
  input  logic [47:0]            clip_offset_frames_i,
  input  logic [8:0]             clip_total_steps_i,
  input  logic [7:0]             hit_step_i,
  input  logic [6:0]             hit_note_i,
  input  logic [6:0]             hit_velocity_i,
  input  logic                   cfg_we_i,
  input  dss_pkg::cfg_reg_e      cfg_index_i,
  input  logic [dss_pkg::CFG_W-1:0] cfg_data_i,
  input  dss_pkg::dss_cmd_t      cmd_i,
  input  logic [ClipW-1:0]       clip_sel_i,
  input  logic [HitW-1:0]        hit_sel_i,
  output dss_pkg::dss_sts_t      sts_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic                   event_valid_o,
  output logic [6:0]             drum_note_o,
  output logic [6:0]             note_velocity_o,
  output logic [11:0]            frame_offset_o,
  output logic                   overflow_o,
  output logic                   last_of_tick_o
);
  import dss_pkg::*;

  localparam longint unsigned NumUnit = longint'(SAMPLE_RATE) * longint'(FRAMES_BPM);
  localparam int unsigned NumW  = $clog2(NumUnit) + 5;
  localparam int unsigned DivW  = NumW + STEP_W + 1;
  localparam int unsigned SumW  = (DivW > 48 ? DivW : 48) + 1;
  localparam int unsigned PosW  = SumW + 1;
  localparam int unsigned Depth = MAX_CLIPS * HITS_PER_CLIP;
  localparam int unsigned AddrW = Depth > 1 ? $clog2(Depth) : 1;
  localparam int unsigned EvW   = $clog2(MAX_EVENTS + 1);

  logic [9:0]  volume_q;
  logic        mute_q;
  logic [6:0]  spb_q;
  logic [4:0]  bpb_q;

  logic [47:0]          start_q [MAX_CLIPS];
  logic [8:0]           len_q   [MAX_CLIPS];
  logic [8:0]           last_q  [MAX_CLIPS];
  logic [MAX_CLIPS-1:0] last_vld_q;

  logic [21:0]      mem [Depth];
  logic [Depth-1:0] mask_q;
  logic [21:0]      rd_q;
  logic             rd_vld_q;

  logic [47:0]      rpos_q;
  logic [12:0]      chunk_q;
  logic [DEN_W-1:0] den_q;
  logic [NumW-1:0]  num_q;
  logic [11:0]      maxoff_q;
  logic             silent_q;
  logic [DivW-1:0]  tpf_q;
  logic [8:0]       cur_q, step_q;
  logic [11:0]      off_q;

  logic             pend_v_q;
  logic [6:0]       pend_note_q, pend_vel_q;
  logic [11:0]      pend_off_q;
  logic [EvW-1:0]   n_q;
  logic             over_q;

  logic        out_valid_q, out_ev_q, out_over_q, out_last_q;
  logic [6:0]  out_note_q, out_vel_q;
  logic [11:0] out_off_q;

  logic             clip_ok, hit_ok, tick_acc;
  logic [ClipW-1:0] ci;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [4:0]       bpb_eff;
  logic [12:0]      chunk_lim;
  logic [8:0]       len_c;
  logic [47:0]      start_c;
  logic [DivW-1:0]  ar_a, ar_p;
  logic [DEN_W-1:0] ar_b;
  logic [NumW-1:0]  ar_d;
  logic             ar_done;
  logic [PosW-1:0]  lpos, lsum;
  logic [DivW-1:0]  lpos_pos;
  logic [SumW-1:0]  sf, rpos_w, diff;
  logic [11:0]      off_new;
  logic [8:0]       cur_new_val;
  logic [16:0]      vel_prod;
  logic [6:0]       vel7;
  logic [8:0]       hs9;
  logic             hit_fire, ev_room, out_free, ev_wait, ev_take, out_push;

  assign clip_ok  = int'(clip_index_i) < int'(MAX_CLIPS);
  assign hit_ok   = clip_ok && (int'(hit_index_i) < int'(HITS_PER_CLIP));
  assign ci       = ClipW'(clip_index_i);
  assign wr_addr  = AddrW'(int'(clip_index_i) * int'(HITS_PER_CLIP) + int'(hit_index_i));
  assign rd_addr  = AddrW'(int'(clip_sel_i) * int'(HITS_PER_CLIP) + int'(hit_sel_i));
  assign tick_acc = accept_i && (opcode_i == OP_TICK);
  assign bpb_eff  = (bpb_q == '0) ? BPB_DEFAULT : bpb_q;
  assign chunk_lim = (chunk_frames_i > CHUNK_LIMIT) ? CHUNK_LIMIT : chunk_frames_i;
  assign len_c    = len_q[clip_sel_i];
  assign start_c  = start_q[clip_sel_i];

  // operand selection for the shared multiplier and divider
  always_comb begin
    case (cmd_i.sel)
      SEL_TPF: begin
        ar_a = DivW'(num_q);
        ar_b = DEN_W'(len_c);
        ar_d = NumW'(den_q);
      end
      SEL_CUR: begin
        ar_a = lpos_pos;
        ar_b = den_q;
        ar_d = num_q;
      end
      SEL_SF: begin
        ar_a = DivW'(num_q);
        ar_b = DEN_W'(step_q);
        ar_d = NumW'(den_q);
      end
      default: begin
        ar_a = '0;
        ar_b = '0;
        ar_d = '0;
      end
    endcase
  end

  dss_arith #(
    .DivW(DivW),
    .NumW(NumW)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mul_go_i(cmd_i.mul_go),
    .div_go_i(cmd_i.div_go),
    .a_i     (ar_a),
    .b_i     (ar_b),
    .d_i     (ar_d),
    .done_o  (ar_done),
    .p_o     (ar_p)
  );

  // chunk position relative to the clip start
  assign lpos     = PosW'(rpos_q) - PosW'(start_c);
  assign lsum     = lpos + PosW'(chunk_q);
  assign lpos_pos = lpos[PosW-1] ? '0 : DivW'(lpos);

  assign sf      = SumW'(ar_p) + SumW'(start_c);
  assign rpos_w  = SumW'(rpos_q);
  assign diff    = (sf > rpos_w) ? sf - rpos_w : '0;
  assign off_new = (diff > SumW'(maxoff_q)) ? maxoff_q : diff[11:0];

  assign cur_new_val = (ar_p >= DivW'(len_c)) ? len_c - 9'd1 : ar_p[8:0];

  assign vel_prod = 17'(rd_q[6:0]) * 17'(volume_q);
  assign vel7     = (vel_prod[16:8] > 9'(VEL_MAX)) ? VEL_MAX : vel_prod[14:8];
  assign hs9      = {1'b0, rd_q[21:14]};
  assign hit_fire = rd_vld_q && (hs9 < len_c) && (hs9 == step_q) && (vel7 != '0);
  assign ev_room  = int'(n_q) < int'(MAX_EVENTS);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ev_wait  = hit_fire && ev_room && pend_v_q && !out_free;
  assign ev_take  = cmd_i.hit_ev && hit_fire && ev_room && !ev_wait;
  assign out_push = (ev_take && pend_v_q) || cmd_i.emit_final;

  always_comb begin
    sts_o            = '0;
    sts_o.silent     = silent_q;
    sts_o.arith_done = ar_done;
    sts_o.clip_live  = (len_c != '0) && (|mask_q[int'(clip_sel_i)*HITS_PER_CLIP +: HITS_PER_CLIP]);
    sts_o.pos_ok     = !lsum[PosW-1] && (lsum != '0) &&
                       ($signed(lpos) < $signed(PosW'(tpf_q)));
    sts_o.cur_new    = !last_vld_q[clip_sel_i] || (last_q[clip_sel_i] != cur_q);
    sts_o.step_last  = step_q == cur_q;
    sts_o.ev_wait    = ev_wait;
    sts_o.out_free   = out_free;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= VOLUME_RESET;
      mute_q   <= 1'b0;
      spb_q    <= SPB_RESET;
      bpb_q    <= BPB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VOLUME: volume_q <= cfg_data_i;
        REG_MUTE:   mute_q   <= cfg_data_i[0];
        REG_SPB:    spb_q    <= cfg_data_i[6:0];
        REG_BPB:    bpb_q    <= cfg_data_i[4:0];
        default:    mute_q   <= mute_q;
      endcase
    end
  end

  // clip table, tracking and hit valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLIPS; c++) begin
        start_q[c] <= '0;
        len_q[c]   <= '0;
        last_q[c]  <= '0;
      end
      last_vld_q <= '0;
      mask_q     <= '0;
    end else begin
      if (accept_i && opcode_i == OP_CLIP && clip_ok) begin
        start_q[ci]    <= clip_offset_frames_i;
        len_q[ci]      <= clip_total_steps_i;
        last_vld_q[ci] <= 1'b0;
      end
      if (accept_i && opcode_i == OP_CLEAR) begin
        last_vld_q <= '0;
      end
      if (accept_i && opcode_i == OP_HIT && hit_ok) begin
        mask_q[wr_addr] <= hit_velocity_i != '0;
      end
      if (cmd_i.upd_last) begin
        last_q[clip_sel_i]     <= cur_q;
        last_vld_q[clip_sel_i] <= 1'b1;
      end
    end
  end

  // hit memory
  always_ff @(posedge clk_i) begin
    if (accept_i && opcode_i == OP_HIT && hit_ok) begin
      mem[wr_addr] <= {hit_step_i, hit_note_i, hit_velocity_i};
    end
    if (cmd_i.hit_rd) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= mask_q[rd_addr];
    end
  end

  // tick operands and step registers
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      rpos_q   <= render_pos_i;
      chunk_q  <= chunk_frames_i;
      den_q    <= DEN_W'(bpm_x256_i) * DEN_W'(spb_q);
      num_q    <= NumW'(NumUnit) * NumW'(bpb_eff);
      maxoff_q <= (chunk_lim == '0) ? 12'd0 : 12'(chunk_lim - 13'd1);
      silent_q <= mute_q || (bpm_x256_i == '0) || (spb_q == '0);
    end
    if (cmd_i.save_tpf) tpf_q <= ar_p;
    if (cmd_i.save_cur) cur_q <= cur_new_val;
    if (cmd_i.save_off) off_q <= off_new;
    if (cmd_i.step_init) begin
      step_q <= (last_vld_q[clip_sel_i] && cur_q > last_q[clip_sel_i]) ?
                last_q[clip_sel_i] + 9'd1 : cur_q;
    end else if (cmd_i.step_inc) begin
      step_q <= step_q + 9'd1;
    end
  end

  // pending event and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      pend_note_q <= '0;
      pend_vel_q  <= '0;
      pend_off_q  <= '0;
      n_q         <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_ev_q    <= 1'b0;
      out_note_q  <= '0;
      out_vel_q   <= '0;
      out_off_q   <= '0;
      out_over_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (tick_acc) begin
        pend_v_q <= 1'b0;
        n_q      <= '0;
        over_q   <= 1'b0;
      end
      if (cmd_i.hit_ev && hit_fire && !ev_room) begin
        over_q <= 1'b1;
      end
      if (ev_take) begin
        pend_v_q    <= 1'b1;
        pend_note_q <= rd_q[13:7];
        pend_vel_q  <= vel7;
        pend_off_q  <= off_q;
        n_q         <= n_q + 1'b1;
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
        out_ev_q    <= pend_v_q;
        out_note_q  <= pend_v_q ? pend_note_q : '0;
        out_vel_q   <= pend_v_q ? pend_vel_q : '0;
        out_off_q   <= pend_v_q ? pend_off_q : '0;
        out_over_q  <= cmd_i.emit_final && over_q;
        out_last_q  <= cmd_i.emit_final;
        if (cmd_i.emit_final) pend_v_q <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_valid_o   = out_ev_q;
  assign drum_note_o     = out_note_q;
  assign note_velocity_o = out_vel_q;
  assign frame_offset_o  = out_off_q;
  assign overflow_o      = out_over_q;
  assign last_of_tick_o  = out_last_q;

endmodule

// ----- rtl/dss_ctrl.sv -----
// ----------------------------------------------------------------------------
// dss_ctrl
// sequencer walking clips, fired steps and hit entries of one tick
// ----------------------------------------------------------------------------
module dss_ctrl #(
  parameter int unsigned MAX_CLIPS     = 4,
  parameter int unsigned HITS_PER_CLIP = 32,
  localparam int unsigned ClipW = MAX_CLIPS > 1 ? $clog2(MAX_CLIPS) : 1,
  localparam int unsigned HitW  = HITS_PER_CLIP > 1 ? $clog2(HITS_PER_CLIP) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  dss_pkg::opcode_e  opcode_i,
  output logic              in_stall_o,
  output logic              accept_o,
  input  dss_pkg::dss_sts_t sts_i,
  output dss_pkg::dss_cmd_t cmd_o,
  output logic [ClipW-1:0]  clip_sel_o,
  output logic [HitW-1:0]   hit_sel_o
);
  import dss_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_START = 17'b00000000000000010,
    S_CLIP  = 17'b00000000000000100,
    S_TMUL  = 17'b00000000000001000,
    S_TDIV  = 17'b00000000000010000,
    S_CHK   = 17'b00000000000100000,
    S_CMUL  = 17'b00000000001000000,
    S_CDIV  = 17'b00000000010000000,
    S_CMP   = 17'b00000000100000000,
    S_SGO   = 17'b00000001000000000,
    S_SMUL  = 17'b00000010000000000,
    S_SDIV  = 17'b00000100000000000,
    S_HRD   = 17'b00001000000000000,
    S_HEV   = 17'b00010000000000000,
    S_NSTEP = 17'b00100000000000000,
    S_NCLIP = 17'b01000000000000000,
    S_FIN   = 17'b10000000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [ClipW-1:0] clip_q, clip_d;
  logic [HitW-1:0]  hit_q, hit_d;

  assign in_stall_o = state_q != S_IDLE;
  assign accept_o   = in_valid_i && (state_q == S_IDLE);
  assign clip_sel_o = clip_q;
  assign hit_sel_o  = hit_q;

  always_comb begin
    state_d = state_q;
    clip_d  = clip_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && opcode_i == OP_TICK) state_d = S_START;
      end
      S_START: begin
        clip_d  = '0;
        state_d = sts_i.silent ? S_FIN : S_CLIP;
      end
      S_CLIP: begin
        if (sts_i.clip_live) begin
          cmd_o.mul_go = 1'b1;
          cmd_o.sel    = SEL_TPF;
          state_d      = S_TMUL;
        end else begin
          state_d = S_NCLIP;
        end
      end
      S_TMUL: begin
        cmd_o.sel = SEL_TPF;
        if (sts_i.arith_done) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_TDIV;
        end
      end
      S_TDIV: begin
        if (sts_i.arith_done) begin
          cmd_o.save_tpf = 1'b1;
          state_d        = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.pos_ok) begin
          cmd_o.mul_go = 1'b1;
          cmd_o.sel    = SEL_CUR;
          state_d      = S_CMUL;
        end else begin
          state_d = S_NCLIP;
        end
      end
      S_CMUL: begin
        cmd_o.sel = SEL_CUR;
        if (sts_i.arith_done) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_CDIV;
        end
      end
      S_CDIV: begin
        if (sts_i.arith_done) begin
          cmd_o.save_cur = 1'b1;
          state_d        = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.cur_new) begin
          cmd_o.step_init = 1'b1;
          state_d         = S_SGO;
        end else begin
          state_d = S_NCLIP;
        end
      end
      S_SGO: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.sel    = SEL_SF;
        state_d      = S_SMUL;
      end
      S_SMUL: begin
        cmd_o.sel = SEL_SF;
        if (sts_i.arith_done) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_SDIV;
        end
      end
      S_SDIV: begin
        if (sts_i.arith_done) begin
          cmd_o.save_off = 1'b1;
          hit_d          = '0;
          state_d        = S_HRD;
        end
      end
      S_HRD: begin
        cmd_o.hit_rd = 1'b1;
        state_d      = S_HEV;
      end
      S_HEV: begin
        cmd_o.hit_ev = 1'b1;
        if (!sts_i.ev_wait) begin
          if (hit_q == HitW'(HITS_PER_CLIP - 1)) begin
            state_d = S_NSTEP;
          end else begin
            hit_d   = hit_q + 1'b1;
            state_d = S_HRD;
          end
        end
      end
      S_NSTEP: begin
        if (sts_i.step_last) begin
          cmd_o.upd_last = 1'b1;
          state_d        = S_NCLIP;
        end else begin
          cmd_o.step_inc = 1'b1;
          state_d        = S_SGO;
        end
      end
      S_NCLIP: begin
        if (clip_q == ClipW'(MAX_CLIPS - 1)) begin
          state_d = S_FIN;
        end else begin
          clip_d  = clip_q + 1'b1;
          state_d = S_CLIP;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      clip_q  <= '0;
      hit_q   <= '0;
    end else begin
      state_q <= state_d;
      clip_q  <= clip_d;
      hit_q   <= hit_d;
    end
  end

endmodule

// ----- rtl/drum_step_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// drum_step_sequencer_top
// clip based drum step sequencer emitting note events per audio chunk
// ----------------------------------------------------------------------------
// usage:
// requests enter on in_valid_i / in_stall_o; clip writes, hit writes and
//   clear tracking are taken without leaving idle and give no result
// a tick request gives one or more result items on out_valid_o / out_stall_i,
//   the final one flagged by last_of_tick_o; an empty tick gives one item
//   with event_valid_o low
// in_stall_o stays high from a tick until its final item is in the output
//   register; the next request can be taken while that item waits
// a tick runs, per clip with hits, up to two multiply and divide pairs on the
//   shared bit-serial unit, plus per fired step one such pair and a read of
//   every hit entry of the clip
// a stalled receiver holds the output register; the sequencer waits when a
//   new event needs that register
// reset clears config to defaults, clip table, tracking and hit valid bits
// config writes on cfg_valid_i / cfg_ready_o are taken any time and are meant
//   for idle periods only
// ----------------------------------------------------------------------------
module drum_step_sequencer_top #(
  parameter int unsigned MAX_CLIPS     = 4,
  parameter int unsigned HITS_PER_CLIP = 32,
  parameter int unsigned SAMPLE_RATE   = 48000,
  parameter int unsigned MAX_EVENTS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [47:0] render_pos_i,
  input  logic [12:0] chunk_frames_i,
  input  logic [17:0] bpm_x256_i,
  input  logic [1:0]  clip_index_i,
  input  logic [4:0]  hit_index_i,
  input  logic [47:0] clip_offset_frames_i,
  input  logic [8:0]  clip_total_steps_i,
  input  logic [7:0]  hit_step_i,
  input  logic [6:0]  hit_note_i,
  input  logic [6:0]  hit_velocity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_valid_o,
  output logic [6:0]  drum_note_o,
  output logic [6:0]  note_velocity_o,
  output logic [11:0] frame_offset_o,
  output logic        overflow_o,
  output logic        last_of_tick_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [dss_pkg::CFG_W-1:0] cfg_data_i
);
  import dss_pkg::*;

  localparam int unsigned ClipW = MAX_CLIPS > 1 ? $clog2(MAX_CLIPS) : 1;
  localparam int unsigned HitW  = HITS_PER_CLIP > 1 ? $clog2(HITS_PER_CLIP) : 1;

  logic             accept;
  dss_cmd_t         cmd;
  dss_sts_t         sts;
  logic [ClipW-1:0] clip_sel;
  logic [HitW-1:0]  hit_sel;
  opcode_e          opcode;

  assign opcode      = opcode_e'(opcode_i);
  assign cfg_ready_o = 1'b1;

  dss_ctrl #(
    .MAX_CLIPS    (MAX_CLIPS),
    .HITS_PER_CLIP(HITS_PER_CLIP)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (opcode),
    .in_stall_o(in_stall_o),
    .accept_o  (accept),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .clip_sel_o(clip_sel),
    .hit_sel_o (hit_sel)
  );

  dss_datapath #(
    .MAX_CLIPS    (MAX_CLIPS),
    .HITS_PER_CLIP(HITS_PER_CLIP),
    .SAMPLE_RATE  (SAMPLE_RATE),
    .MAX_EVENTS   (MAX_EVENTS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .opcode_i            (opcode),
    .render_pos_i        (render_pos_i),
    .chunk_frames_i      (chunk_frames_i),
    .bpm_x256_i          (bpm_x256_i),
    .clip_index_i        (clip_index_i),
    .hit_index_i         (hit_index_i),
    .clip_offset_frames_i(clip_offset_frames_i),
    .clip_total_steps_i  (clip_total_steps_i),
    .hit_step_i          (hit_step_i),
    .hit_note_i          (hit_note_i),
    .hit_velocity_i      (hit_velocity_i),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd),
    .clip_sel_i          (clip_sel),
    .hit_sel_i           (hit_sel),
    .sts_o               (sts),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .event_valid_o       (event_valid_o),
    .drum_note_o         (drum_note_o),
    .note_velocity_o     (note_velocity_o),
    .frame_offset_o      (frame_offset_o),
    .overflow_o          (overflow_o),
    .last_of_tick_o      (last_of_tick_o)
  );

endmodule

// ----- rtl/dss_checker.sv -----
// ----------------------------------------------------------------------------
// dss_checker
// port-level checks on the drum step sequencer results
// ----------------------------------------------------------------------------
`include "drum_step_sequencer_top_macros.svh"

module dss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] opcode_i,
  input logic       out_valid_o,
  input logic       event_valid_o,
  input logic [6:0] note_velocity_o,
  input logic       overflow_o,
  input logic       last_of_tick_o
);
  import dss_pkg::*;

  `DSS_ASSERT_SAME(a_empty_is_last, out_valid_o && !event_valid_o, last_of_tick_o, "empty item not final")
  `DSS_ASSERT_SAME(a_over_on_last, out_valid_o && overflow_o, last_of_tick_o && event_valid_o, "overflow off final event")
  `DSS_ASSERT_SAME(a_vel_nonzero, out_valid_o && event_valid_o, note_velocity_o != 7'd0, "event with zero velocity")
  `DSS_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && opcode_i == OP_TICK, in_stall_o, "tick not held busy")

endmodule

bind drum_step_sequencer_top dss_checker u_dss_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum step sequencer testbench
// drives clip, hit, clear and tick requests with random gaps and output
// stalls; a scoreboard predicts the note events of every tick and checks
// them field by field in order
// ----------------------------------------------------------------------------
module tb;
  import dss_pkg::*;

  localparam int CLIPS = 4;
  localparam int HITS = 32;
  localparam int WATCH_LIMIT = 2000000;

  typedef struct {
    bit        ev;
    bit [6:0]  note;
    bit [6:0]  vel;
    bit [11:0] off;
    bit        ovf;
    bit        last;
  } note_event_t;

  class seq_scoreboard;
    note_event_t expected[$];
    int          errors;
    bit [9:0]    volume;
    bit          muted;
    bit [6:0]    spb;
    bit [4:0]    bpb;
    int          last_step[CLIPS];
    bit [47:0]   clip_start[CLIPS];
    bit [8:0]    clip_len[CLIPS];
    bit [7:0]    hit_step[CLIPS][HITS];
    bit [6:0]    hit_note[CLIPS][HITS];
    bit [6:0]    hit_vel[CLIPS][HITS];

    function new();
      errors = 0;
      volume = 10'd256;
      muted = 1'b0;
      spb = 7'd16;
      bpb = 5'd4;
      for (int c = 0; c < CLIPS; c++) begin
        last_step[c] = -1;
        clip_start[c] = '0;
        clip_len[c] = '0;
        for (int h = 0; h < HITS; h++) begin
          hit_step[c][h] = '0;
          hit_note[c][h] = '0;
          hit_vel[c][h] = '0;
        end
      end
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void set_reg(cfg_reg_e idx, bit [9:0] v);
      case (idx)
        REG_VOLUME: volume = v;
        REG_MUTE:   muted = v[0];
        REG_SPB:    spb = v[6:0];
        REG_BPB:    bpb = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(opcode_e op, bit [47:0] rpos, bit [12:0] chunk,
                               bit [17:0] bpm, bit [1:0] ci, bit [4:0] hi,
                               bit [47:0] cstart, bit [8:0] clen, bit [7:0] hstep,
                               bit [6:0] hnote, bit [6:0] hvel);
      note_event_t evs[$];
      note_event_t e;
      longint unsigned num, den, maxoff, tpf, sf, off, vel;
      longint lpos;
      int total, cur, prev, cnt, stp;
      bit any, over;
      over = 0;
      case (op)
        OP_CLIP: begin
          clip_start[ci] = cstart;
          clip_len[ci] = clen;
          last_step[ci] = -1;
          return;
        end
        OP_HIT: begin
          hit_step[ci][hi] = hstep;
          hit_note[ci][hi] = hnote;
          hit_vel[ci][hi] = hvel;
          return;
        end
        OP_CLEAR: begin
          for (int c = 0; c < CLIPS; c++) last_step[c] = -1;
          return;
        end
        default: ;
      endcase
      if (!muted && bpm != 0 && spb != 0) begin
        num = 64'd737280000 * (bpb != 0 ? bpb : 5'd4);
        den = longint'(bpm) * spb;
        maxoff = chunk > 13'd4096 ? 4096 : chunk;
        maxoff = maxoff != 0 ? maxoff - 1 : 0;
        for (int c = 0; c < CLIPS; c++) begin
          total = clip_len[c];
          if (total == 0) continue;
          any = 0;
          for (int h = 0; h < HITS; h++) if (hit_vel[c][h] != 0) any = 1;
          if (!any) continue;
          tpf = num * total / den;
          lpos = longint'(rpos) - longint'(clip_start[c]);
          if (lpos + longint'(chunk) <= 0) continue;
          if (lpos >= longint'(tpf)) continue;
          if (lpos < 0) lpos = 0;
          cur = int'(longint'(lpos) * den / num);
          if (cur > total - 1) cur = total - 1;
          prev = last_step[c];
          if (cur == prev) continue;
          if (prev < 0) cnt = 1;
          else begin
            cnt = cur - prev;
            if (cnt <= 0) cnt = 1;
            if (cnt > total) cnt = total;
          end
          for (int i = 0; i < cnt; i++) begin
            if (prev < 0 || cnt == 1) stp = cur;
            else begin
              stp = prev + 1 + i;
              if (stp >= total) break;
            end
            sf = num * stp / den + clip_start[c];
            off = sf > rpos ? sf - rpos : 0;
            if (off > maxoff) off = maxoff;
            for (int h = 0; h < HITS; h++) begin
              if (hit_step[c][h] >= total || hit_step[c][h] != stp) continue;
              vel = (longint'(hit_vel[c][h]) * volume) >> 8;
              if (vel > 127) vel = 127;
              if (vel == 0) continue;
              if (evs.size() >= 64) begin
                over = 1;
                continue;
              end
              e.ev = 1;
              e.note = hit_note[c][h];
              e.vel = vel[6:0];
              e.off = off[11:0];
              e.ovf = 0;
              e.last = 0;
              evs = {evs, e};
            end
          end
          last_step[c] = cur;
        end
      end
      if (evs.size() == 0) begin
        e = '{0, 0, 0, 0, 0, 1};
        evs = {evs, e};
      end else begin
        evs[evs.size()-1].ovf = over;
        evs[evs.size()-1].last = 1;
      end
      foreach (evs[k]) expected = {expected, evs[k]};
    endfunction

    function void check_result(note_event_t got);
      note_event_t w;
      if (expected.size() == 0) begin
        report("result with no expected event");
        return;
      end
      w = expected.pop_front();
      if (got.ev != w.ev) report($sformatf("event_valid %0d exp %0d", got.ev, w.ev));
      if (got.note != w.note) report($sformatf("drum_note %0d exp %0d", got.note, w.note));
      if (got.vel != w.vel) report($sformatf("velocity %0d exp %0d", got.vel, w.vel));
      if (got.off != w.off) report($sformatf("frame_offset %0d exp %0d", got.off, w.off));
      if (got.ovf != w.ovf) report($sformatf("overflow %0d exp %0d", got.ovf, w.ovf));
      if (got.last != w.last) report($sformatf("last_of_tick %0d exp %0d", got.last, w.last));
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [47:0] render_pos_i = '0;
  logic [12:0] chunk_frames_i = '0;
  logic [17:0] bpm_x256_i = '0;
  logic [1:0]  clip_index_i = '0;
  logic [4:0]  hit_index_i = '0;
  logic [47:0] clip_offset_frames_i = '0;
  logic [8:0]  clip_total_steps_i = '0;
  logic [7:0]  hit_step_i = '0;
  logic [6:0]  hit_note_i = '0;
  logic [6:0]  hit_velocity_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        event_valid_o;
  logic [6:0]  drum_note_o;
  logic [6:0]  note_velocity_o;
  logic [11:0] frame_offset_o;
  logic        overflow_o;
  logic        last_of_tick_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  seq_scoreboard sb = new();
  int  stall_left = 0;
  bit  calm = 0;
  int  idle_cycles = 0;
  bit  [47:0] play_pos = 0;
  bit  [47:0] clip_base = 0;
  bit  dense = 0;

  drum_step_sequencer_top uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    note_event_t got;
    if (out_valid_o && !out_stall_i) begin
      got = '{event_valid_o, drum_note_o, note_velocity_o, frame_offset_o,
              overflow_o, last_of_tick_o};
      sb.check_result(got);
      stall_left <= calm ? 0 : $urandom_range(0, 8);
      out_stall_i <= !calm && ($urandom_range(0, 1) == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL drum_step_sequencer_top");
      $finish;
    end
  end

  task automatic send(opcode_e op, bit [47:0] rpos, bit [12:0] chunk, bit [17:0] bpm,
                      bit [1:0] ci, bit [4:0] hi, bit [47:0] cstart, bit [8:0] clen,
                      bit [7:0] hstep, bit [6:0] hnote, bit [6:0] hvel);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    render_pos_i <= rpos;
    chunk_frames_i <= chunk;
    bpm_x256_i <= bpm;
    clip_index_i <= ci;
    hit_index_i <= hi;
    clip_offset_frames_i <= cstart;
    clip_total_steps_i <= clen;
    hit_step_i <= hstep;
    hit_note_i <= hnote;
    hit_velocity_i <= hvel;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, rpos, chunk, bpm, ci, hi, cstart, clen, hstep, hnote, hvel);
  endtask

  task automatic tick(bit [47:0] rpos, bit [12:0] chunk, bit [17:0] bpm);
    send(OP_TICK, rpos, chunk, bpm, 2'($urandom), 5'($urandom), 48'({$urandom, $urandom}),
         9'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  task automatic put_clip(bit [1:0] ci, bit [47:0] cstart, bit [8:0] clen);
    send(OP_CLIP, 48'({$urandom, $urandom}), 13'($urandom), 18'($urandom), ci,
         5'($urandom), cstart, clen, 8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  task automatic put_hit(bit [1:0] ci, bit [4:0] hi, bit [7:0] st, bit [6:0] nt,
                         bit [6:0] vl);
    send(OP_HIT, 48'({$urandom, $urandom}), 13'($urandom), 18'($urandom), ci, hi,
         48'({$urandom, $urandom}), 9'($urandom), st, nt, vl);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [9:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int r;
    bit [12:0] ch;
    bit [17:0] bpm;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      ch = $urandom_range(0, 19) == 0 ? 13'($urandom) : 13'($urandom_range(64, 2048));
      bpm = $urandom_range(0, 19) == 0 ? 18'($urandom) : 18'($urandom_range(30720, 256000));
      if (r < 10) begin
        put_clip(2'($urandom), clip_base + 48'($urandom_range(0, 60000)),
                 $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(1, 24)));
      end else if (r < 25) begin
        put_hit(2'($urandom), 5'($urandom), dense ? 8'($urandom_range(0, 1))
                : ($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 24))),
                7'($urandom), $urandom_range(0, 7) == 0 ? 7'd0 : 7'($urandom));
      end else if (r < 28) begin
        send(OP_CLEAR, 48'({$urandom, $urandom}), 13'($urandom), 18'($urandom),
             2'($urandom), 5'($urandom), 48'({$urandom, $urandom}), 9'($urandom),
             8'($urandom), 7'($urandom), 7'($urandom));
      end else if (r < 33) begin
        play_pos = clip_base + 48'($urandom_range(0, 80000));
        tick(play_pos, ch, bpm);
      end else if (r < 35) begin
        tick(48'({$urandom, $urandom}), ch, bpm);
      end else begin
        tick(play_pos, ch, bpm);
        play_pos = play_pos + 48'(ch);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings, directed cases
    calm = 1;
    write_reg(REG_VOLUME, 10'd256);
    write_reg(REG_MUTE, 10'd0);
    write_reg(REG_SPB, 10'd16);
    write_reg(REG_BPB, 10'd4);
    tick(48'd0, 13'd512, 18'd30720);
    put_clip(2'd0, 48'd1000, 9'd16);
    put_hit(2'd0, 5'd0, 8'd0, 7'd36, 7'd127);
    put_hit(2'd0, 5'd31, 8'd3, 7'd127, 7'd1);
    put_hit(2'd0, 5'd1, 8'd255, 7'd0, 7'd100);
    put_hit(2'd0, 5'd2, 8'd5, 7'd42, 7'd0);
    tick(48'd0, 13'd4096, 18'd30720);
    tick(48'd4096, 13'd4096, 18'd30720);
    tick(48'd30000, 13'd8191, 18'd30720);
    tick(48'd2000, 13'd0, 18'd30720);
    tick(48'd20000, 13'd1, 18'd0);
    tick(48'd20000, 13'd512, 18'h3FFFF);
    put_clip(2'd3, 48'hFFFF_FFFF_F000, 9'd256);
    put_hit(2'd3, 5'd31, 8'd255, 7'd60, 7'd90);
    put_hit(2'd3, 5'd0, 8'd0, 7'd61, 7'd64);
    tick(48'hFFFF_FFFF_F000, 13'd4096, 18'd256000);
    tick(48'hFFFF_FFFF_FE00, 13'd512, 18'd256000);
    send(OP_CLEAR, 48'd0, 13'd0, 18'd0, 2'd0, 5'd0, 48'd0, 9'd0, 8'd0, 7'd0, 7'd0);
    tick(48'hFFFF_FFFF_FE00, 13'd512, 18'd256000);
    put_clip(2'd3, 48'd0, 9'd0);
    tick(48'd1000, 13'd512, 18'd30720);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin write_reg(REG_VOLUME, 10'd512); write_reg(REG_SPB, 10'd64);
           write_reg(REG_BPB, 10'd16); end
        1: begin write_reg(REG_VOLUME, 10'd1); write_reg(REG_SPB, 10'd1);
           write_reg(REG_BPB, 10'd1); end
        2: begin write_reg(REG_VOLUME, 10'd1023); write_reg(REG_SPB, 10'd127);
           write_reg(REG_BPB, 10'd0); end
        3: begin write_reg(REG_MUTE, 10'd1); write_reg(REG_VOLUME, 10'd0); end
        4: begin write_reg(REG_MUTE, 10'd0); write_reg(REG_SPB, 10'd0);
           write_reg(REG_BPB, 10'd31); end
        default: begin write_reg(REG_VOLUME, 10'd300); write_reg(REG_SPB, 10'd16);
           write_reg(REG_BPB, 10'd4); end
      endcase
      calm = (p == 1);
      dense = (p == 5);
      clip_base = (p == 2) ? 48'({$urandom, $urandom}) : 48'($urandom_range(0, 100000));
      play_pos = clip_base;
      random_phase(p == 5 ? 60 : 32);
      settle();
    end

    if (sb.errors == 0) begin
      $display("PASS drum_step_sequencer_top");
    end else begin
      $display("FAIL drum_step_sequencer_top");
    end
    $finish;
  end
endmodule
